// ----- rtl/csa_pkg.sv -----
`default_nettype none
package csa_pkg;

  localparam int unsigned CHUNK_W = 4;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned BASE_W  = 21;

  localparam int unsigned DEF_MAX_CHUNKS   = 16;
  localparam int unsigned DEF_FREE_ENTRIES = 64;
  localparam int unsigned DEF_USED_ENTRIES = 64;

  localparam logic [SIZE_W-1:0] CS_RESET = 17'd4096;
  localparam logic [SIZE_W-1:0] CS_MAX   = 17'd65536;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_ALLOC = 3'd1,
    ST_NO_CHUNK  = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef struct packed {
    logic               vld;
    logic [CHUNK_W-1:0] chunk;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
  } seg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_USCAN,
    S_FSCAN,
    S_DRAIN,
    S_DECIDE,
    S_WRITE,
    S_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_USCAN,
    CMD_FSCAN,
    CMD_DECIDE,
    CMD_WR1,
    CMD_WR2
  } dp_cmd_e;

endpackage
`default_nettype wire

// ----- rtl/csa_ctrl.sv -----
`default_nettype none
module csa_ctrl #(
  parameter int unsigned FreeEntries = csa_pkg::DEF_FREE_ENTRIES,
  parameter int unsigned UsedEntries = csa_pkg::DEF_USED_ENTRIES,
  localparam int unsigned MaxEnt = (FreeEntries > UsedEntries) ? FreeEntries : UsedEntries,
  localparam int unsigned CntW = $clog2(MaxEnt + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      csa_pkg::dp_cmd_e  cmd_o,
  output      logic [CntW-1:0]   cnt_o
);

  csa_pkg::ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr2_q, wr2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csa_pkg::S_CLEAR;
      cnt_q   <= '0;
      wr2_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wr2_q   <= wr2_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wr2_d       = wr2_q;
    cmd_o       = csa_pkg::CMD_NONE;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      csa_pkg::S_CLEAR: begin
        cmd_o = csa_pkg::CMD_CLEAR;
        if (cnt_q == CntW'(MaxEnt - 1)) begin
          cnt_d   = '0;
          state_d = csa_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      csa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = csa_pkg::CMD_LOAD;
          cnt_d   = '0;
          state_d = csa_pkg::S_USCAN;
        end
      end
      csa_pkg::S_USCAN: begin
        cmd_o = csa_pkg::CMD_USCAN;
        if (cnt_q == CntW'(UsedEntries - 1)) begin
          cnt_d   = '0;
          state_d = csa_pkg::S_FSCAN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      csa_pkg::S_FSCAN: begin
        cmd_o = csa_pkg::CMD_FSCAN;
        if (cnt_q == CntW'(FreeEntries - 1)) begin
          cnt_d   = '0;
          state_d = csa_pkg::S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      csa_pkg::S_DRAIN: begin
        state_d = csa_pkg::S_DECIDE;
      end
      csa_pkg::S_DECIDE: begin
        cmd_o   = csa_pkg::CMD_DECIDE;
        wr2_d   = 1'b0;
        state_d = csa_pkg::S_WRITE;
      end
      csa_pkg::S_WRITE: begin
        if (!wr2_q) begin
          cmd_o = csa_pkg::CMD_WR1;
          wr2_d = 1'b1;
        end else begin
          cmd_o   = csa_pkg::CMD_WR2;
          state_d = csa_pkg::S_OUT;
        end
      end
      csa_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = csa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = csa_pkg::S_IDLE;
      end
    endcase
  end

  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

// ----- rtl/csa_datapath.sv -----
`default_nettype none
module csa_datapath #(
  parameter int unsigned MaxChunks   = csa_pkg::DEF_MAX_CHUNKS,
  parameter int unsigned FreeEntries = csa_pkg::DEF_FREE_ENTRIES,
  parameter int unsigned UsedEntries = csa_pkg::DEF_USED_ENTRIES,
  localparam int unsigned MaxEnt = (FreeEntries > UsedEntries) ? FreeEntries : UsedEntries,
  localparam int unsigned CntW = $clog2(MaxEnt + 1),
  localparam int unsigned FiW  = $clog2(FreeEntries),
  localparam int unsigned UiW  = $clog2(UsedEntries)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire csa_pkg::dp_cmd_e              cmd_i,
  input  wire logic [CntW-1:0]               cnt_i,
  input  wire logic                          op_i,
  input  wire logic [csa_pkg::SIZE_W-1:0]    request_size_i,
  input  wire logic [csa_pkg::ADDR_W-1:0]    address_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [csa_pkg::SIZE_W-1:0]    cfg_data_i,
  output      logic [csa_pkg::ADDR_W-1:0]    granted_address_o,
  output      logic [2:0]                    status_o
);

  localparam int unsigned SW = csa_pkg::SIZE_W;
  localparam int unsigned AW = csa_pkg::ADDR_W;
  localparam int unsigned BW = csa_pkg::BASE_W;

  csa_pkg::seg_t fmem [FreeEntries];
  csa_pkg::seg_t umem [UsedEntries];

  logic [SW-1:0]                 cs_q;
  logic [csa_pkg::COUNT_W-1:0]   chunks_q;
  logic [BW-1:0]                 base_q;
  logic                          op_q;
  logic [SW-1:0]                 req_q;
  logic [AW-1:0]                 addr_q;

  csa_pkg::seg_t  f_rd_q, u_rd_q;
  logic           f_pend_q, u_pend_q;
  logic [FiW-1:0] f_idx_q;
  logic [UiW-1:0] u_idx_q;

  logic           ue_found_q, um_found_q;
  logic [UiW-1:0] ue_idx_q, um_idx_q;
  csa_pkg::seg_t  um_seg_q;

  logic           fe_found_q, best_found_q, l_found_q, r_found_q;
  logic [FiW-1:0] fe_idx_q, best_idx_q, l_idx_q, r_idx_q;
  csa_pkg::seg_t  best_seg_q, l_seg_q, r_seg_q;

  logic           fa_en_q, fa_en_d, fb_en_q, fb_en_d, uw_en_q, uw_en_d;
  logic [FiW-1:0] fa_idx_q, fa_idx_d, fb_idx_q, fb_idx_d;
  logic [UiW-1:0] uw_idx_q, uw_idx_d;
  csa_pkg::seg_t  fa_word_q, fa_word_d, fb_word_q, fb_word_d, uw_word_q, uw_word_d;
  logic [2:0]     stat_q, stat_d;
  logic [AW-1:0]  grant_q, grant_d;
  logic           open_d;

  logic [SW-1:0] cs_eff;
  logic [BW-1:0] s_end, f_end;
  logic          is_r, is_l, better;

  always_ff @(posedge clk_i) begin
    if (cmd_i == csa_pkg::CMD_CLEAR) begin
      if (cnt_i < CntW'(FreeEntries)) begin
        fmem[cnt_i[FiW-1:0]] <= '0;
      end
    end else if (cmd_i == csa_pkg::CMD_WR1 && fa_en_q) begin
      fmem[fa_idx_q] <= fa_word_q;
    end else if (cmd_i == csa_pkg::CMD_WR2 && fb_en_q) begin
      fmem[fb_idx_q] <= fb_word_q;
    end
    if (cmd_i == csa_pkg::CMD_FSCAN) begin
      f_rd_q <= fmem[cnt_i[FiW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == csa_pkg::CMD_CLEAR) begin
      if (cnt_i < CntW'(UsedEntries)) begin
        umem[cnt_i[UiW-1:0]] <= '0;
      end
    end else if (cmd_i == csa_pkg::CMD_WR1 && uw_en_q) begin
      umem[uw_idx_q] <= uw_word_q;
    end
    if (cmd_i == csa_pkg::CMD_USCAN) begin
      u_rd_q <= umem[cnt_i[UiW-1:0]];
    end
  end

  assign cs_eff = (cs_q > csa_pkg::CS_MAX) ? csa_pkg::CS_MAX : cs_q;
  assign s_end  = BW'(um_seg_q.addr) + BW'(um_seg_q.size);
  assign f_end  = BW'(f_rd_q.addr) + BW'(f_rd_q.size);
  assign is_r   = f_rd_q.vld && (f_rd_q.chunk == um_seg_q.chunk) &&
                  (BW'(f_rd_q.addr) == s_end);
  assign is_l   = f_rd_q.vld && (f_rd_q.chunk == um_seg_q.chunk) && !is_r &&
                  (f_end == BW'(um_seg_q.addr));
  assign better = f_rd_q.vld && (f_rd_q.size > req_q) &&
                  (!best_found_q || (f_rd_q.size < best_seg_q.size) ||
                   ((f_rd_q.size == best_seg_q.size) && (f_rd_q.addr < best_seg_q.addr)));

  always_comb begin
    fa_en_d   = 1'b0;
    fa_idx_d  = fe_idx_q;
    fa_word_d = '0;
    fb_en_d   = 1'b0;
    fb_idx_d  = r_idx_q;
    fb_word_d = '0;
    uw_en_d   = 1'b0;
    uw_idx_d  = ue_idx_q;
    uw_word_d = '0;
    stat_d    = csa_pkg::ST_OK;
    grant_d   = '0;
    open_d    = 1'b0;
    if (op_q == csa_pkg::OP_RESERVE) begin
      if (req_q == '0 || req_q > cs_eff) begin
        stat_d = csa_pkg::ST_BAD_SIZE;
      end else if (!ue_found_q) begin
        stat_d = csa_pkg::ST_FULL;
      end else if (best_found_q) begin
        fa_en_d   = 1'b1;
        fa_idx_d  = best_idx_q;
        fa_word_d = '{vld: 1'b1, chunk: best_seg_q.chunk,
                      addr: best_seg_q.addr + AW'(req_q),
                      size: best_seg_q.size - req_q};
        uw_en_d   = 1'b1;
        uw_word_d = '{vld: 1'b1, chunk: best_seg_q.chunk, addr: best_seg_q.addr,
                      size: req_q};
        grant_d   = best_seg_q.addr;
      end else if (chunks_q >= csa_pkg::COUNT_W'(MaxChunks)) begin
        stat_d = csa_pkg::ST_NO_CHUNK;
      end else if (cs_eff > req_q && !fe_found_q) begin
        stat_d = csa_pkg::ST_FULL;
      end else begin
        open_d    = 1'b1;
        fa_en_d   = cs_eff > req_q;
        fa_word_d = '{vld: 1'b1, chunk: chunks_q[csa_pkg::CHUNK_W-1:0],
                      addr: base_q[AW-1:0] + AW'(req_q), size: cs_eff - req_q};
        uw_en_d   = 1'b1;
        uw_word_d = '{vld: 1'b1, chunk: chunks_q[csa_pkg::CHUNK_W-1:0],
                      addr: base_q[AW-1:0], size: req_q};
        grant_d   = base_q[AW-1:0];
      end
    end else begin
      if (!um_found_q) begin
        stat_d = csa_pkg::ST_NOT_ALLOC;
      end else if (!l_found_q && !r_found_q && !fe_found_q) begin
        stat_d = csa_pkg::ST_FULL;
      end else begin
        uw_en_d   = 1'b1;
        uw_idx_d  = um_idx_q;
        uw_word_d = um_seg_q;
        uw_word_d.vld = 1'b0;
        fa_en_d   = 1'b1;
        if (l_found_q) begin
          fa_idx_d  = l_idx_q;
          fa_word_d = l_seg_q;
          fa_word_d.size = l_seg_q.size + um_seg_q.size +
                           (r_found_q ? r_seg_q.size : '0);
          fb_en_d   = r_found_q;
          fb_word_d = '0;
        end else if (r_found_q) begin
          fa_idx_d  = r_idx_q;
          fa_word_d = r_seg_q;
          fa_word_d.addr = um_seg_q.addr;
          fa_word_d.size = r_seg_q.size + um_seg_q.size;
        end else begin
          fa_word_d = um_seg_q;
          fa_word_d.vld = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q     <= csa_pkg::CS_RESET;
      chunks_q <= '0;
      base_q   <= '0;
      f_pend_q <= 1'b0;
      u_pend_q <= 1'b0;
      fa_en_q  <= 1'b0;
      fb_en_q  <= 1'b0;
      uw_en_q  <= 1'b0;
      stat_q   <= '0;
      grant_q  <= '0;
    end else begin
      if (cfg_we_i && chunks_q == '0) begin
        cs_q <= cfg_data_i;
      end
      f_pend_q <= (cmd_i == csa_pkg::CMD_FSCAN);
      u_pend_q <= (cmd_i == csa_pkg::CMD_USCAN);
      if (cmd_i == csa_pkg::CMD_DECIDE) begin
        fa_en_q <= fa_en_d;
        fb_en_q <= fb_en_d;
        uw_en_q <= uw_en_d;
        stat_q  <= stat_d;
        grant_q <= grant_d;
        if (open_d) begin
          chunks_q <= chunks_q + 1'b1;
          base_q   <= base_q + BW'(cs_eff);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_idx_q <= cnt_i[FiW-1:0];
    u_idx_q <= cnt_i[UiW-1:0];
    if (cmd_i == csa_pkg::CMD_LOAD) begin
      op_q         <= op_i;
      req_q        <= request_size_i;
      addr_q       <= address_i;
      ue_found_q   <= 1'b0;
      um_found_q   <= 1'b0;
      fe_found_q   <= 1'b0;
      best_found_q <= 1'b0;
      l_found_q    <= 1'b0;
      r_found_q    <= 1'b0;
    end
    if (u_pend_q) begin
      if (!u_rd_q.vld && !ue_found_q) begin
        ue_found_q <= 1'b1;
        ue_idx_q   <= u_idx_q;
      end
      if (u_rd_q.vld && u_rd_q.addr == addr_q && !um_found_q) begin
        um_found_q <= 1'b1;
        um_idx_q   <= u_idx_q;
        um_seg_q   <= u_rd_q;
      end
    end
    if (f_pend_q) begin
      if (!f_rd_q.vld && !fe_found_q) begin
        fe_found_q <= 1'b1;
        fe_idx_q   <= f_idx_q;
      end
      if (better) begin
        best_found_q <= 1'b1;
        best_idx_q   <= f_idx_q;
        best_seg_q   <= f_rd_q;
      end
      if (is_r) begin
        r_found_q <= 1'b1;
        r_idx_q   <= f_idx_q;
        r_seg_q   <= f_rd_q;
      end
      if (is_l) begin
        l_found_q <= 1'b1;
        l_idx_q   <= f_idx_q;
        l_seg_q   <= f_rd_q;
      end
    end
    if (cmd_i == csa_pkg::CMD_DECIDE) begin
      fa_idx_q  <= fa_idx_d;
      fa_word_q <= fa_word_d;
      fb_idx_q  <= fb_idx_d;
      fb_word_q <= fb_word_d;
      uw_idx_q  <= uw_idx_d;
      uw_word_q <= uw_word_d;
    end
  end

  assign granted_address_o = grant_q;
  assign status_o          = stat_q;

endmodule
`default_nettype wire

// ----- rtl/coalescing_segment_allocator_unit.sv -----
// After acceptance each word passes through a scan of the used table, then a scan of the
// free table (one entry per cycle each, each table held in a single-port memory), then a
// decision step and the table writes, before its result is shown.
// One word is in flight at a time, so the next word is accepted only after the result of
// the previous one has been taken.
// After reset the block clears both tables and stalls its input meanwhile; chunk_size
// writes take effect only while no chunk is open.
`default_nettype none
module coalescing_segment_allocator_unit #(
  parameter int unsigned MaxChunks   = csa_pkg::DEF_MAX_CHUNKS,
  parameter int unsigned FreeEntries = csa_pkg::DEF_FREE_ENTRIES,
  parameter int unsigned UsedEntries = csa_pkg::DEF_USED_ENTRIES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic                       op_i,
  input  wire logic [csa_pkg::SIZE_W-1:0] request_size_i,
  input  wire logic [csa_pkg::ADDR_W-1:0] address_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [csa_pkg::ADDR_W-1:0] granted_address_o,
  output      logic [2:0]                 status_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [csa_pkg::SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned MaxEnt = (FreeEntries > UsedEntries) ? FreeEntries : UsedEntries;
  localparam int unsigned CntW   = $clog2(MaxEnt + 1);

  csa_pkg::dp_cmd_e cmd;
  logic [CntW-1:0]  cnt;

  csa_ctrl #(
    .FreeEntries(FreeEntries),
    .UsedEntries(UsedEntries)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .cnt_o      (cnt)
  );

  csa_datapath #(
    .MaxChunks  (MaxChunks),
    .FreeEntries(FreeEntries),
    .UsedEntries(UsedEntries)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cnt_i            (cnt),
    .op_i             (op_i),
    .request_size_i   (request_size_i),
    .address_i        (address_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .granted_address_o(granted_address_o),
    .status_o         (status_o)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned AW = csa_pkg::ADDR_W;
  localparam int unsigned SW = csa_pkg::SIZE_W;

  class segment_scoreboard;
    int unsigned chunk_size;
    int unsigned chunks_open;
    csa_pkg::seg_t free_seg[csa_pkg::DEF_FREE_ENTRIES];
    csa_pkg::seg_t used_seg[csa_pkg::DEF_USED_ENTRIES];
    logic [AW-1:0] exp_addr_q[$];
    csa_pkg::status_e exp_status_q[$];
    int unsigned errors;

    function new();
      chunk_size = csa_pkg::CS_RESET;
      chunks_open = 0;
      errors = 0;
      foreach (free_seg[i]) free_seg[i] = '0;
      foreach (used_seg[i]) used_seg[i] = '0;
    endfunction

    function void note_cfg(logic [SW-1:0] value);
      if (chunks_open == 0) chunk_size = value;
    endfunction

    function int first_free_slot();
      foreach (free_seg[i]) if (!free_seg[i].vld) return i;
      return -1;
    endfunction

    function int first_used_slot();
      foreach (used_seg[i]) if (!used_seg[i].vld) return i;
      return -1;
    endfunction

    function logic [AW-1:0] pick_allocated();
      logic [AW-1:0] addrs[$];
      foreach (used_seg[i]) if (used_seg[i].vld) addrs.push_back(used_seg[i].addr);
      if (addrs.size() == 0) return AW'($urandom());
      return addrs[$urandom_range(addrs.size() - 1)];
    endfunction

    function csa_pkg::status_e reserve(int unsigned req, output logic [AW-1:0] granted);
      int unsigned cs;
      int best;
      int uslot;
      int fslot;
      csa_pkg::seg_t s;
      cs = (chunk_size > 65536) ? 65536 : chunk_size;
      best = -1;
      granted = '0;
      if (req == 0 || req > cs) return csa_pkg::ST_BAD_SIZE;
      foreach (free_seg[i]) begin
        if (!free_seg[i].vld || int'(free_seg[i].size) <= req) continue;
        if (best < 0 || free_seg[i].size < free_seg[best].size ||
            (free_seg[i].size == free_seg[best].size &&
             free_seg[i].addr < free_seg[best].addr)) best = i;
      end
      uslot = first_used_slot();
      if (uslot < 0) return csa_pkg::ST_FULL;
      if (best >= 0) begin
        s = free_seg[best];
        free_seg[best].addr = s.addr + AW'(req);
        free_seg[best].size = s.size - SW'(req);
      end else begin
        fslot = -1;
        if (chunks_open >= csa_pkg::DEF_MAX_CHUNKS) return csa_pkg::ST_NO_CHUNK;
        if (cs > req) begin
          fslot = first_free_slot();
          if (fslot < 0) return csa_pkg::ST_FULL;
        end
        s.vld = 1'b1;
        s.chunk = csa_pkg::CHUNK_W'(chunks_open);
        s.addr = AW'(chunks_open * cs);
        s.size = SW'(cs);
        chunks_open++;
        if (fslot >= 0) begin
          free_seg[fslot].vld = 1'b1;
          free_seg[fslot].chunk = s.chunk;
          free_seg[fslot].addr = s.addr + AW'(req);
          free_seg[fslot].size = SW'(cs - req);
        end
      end
      used_seg[uslot].vld = 1'b1;
      used_seg[uslot].chunk = s.chunk;
      used_seg[uslot].addr = s.addr;
      used_seg[uslot].size = SW'(req);
      granted = s.addr;
      return csa_pkg::ST_OK;
    endfunction

    function csa_pkg::status_e release_seg(logic [AW-1:0] addr);
      int u;
      int l;
      int r;
      int slot;
      csa_pkg::seg_t s;
      u = -1;
      l = -1;
      r = -1;
      slot = -1;
      foreach (used_seg[i]) if (u < 0 && used_seg[i].vld && used_seg[i].addr == addr) u = i;
      if (u < 0) return csa_pkg::ST_NOT_ALLOC;
      s = used_seg[u];
      foreach (free_seg[i]) begin
        if (!free_seg[i].vld || free_seg[i].chunk != s.chunk) continue;
        if (int'(free_seg[i].addr) == int'(s.addr) + int'(s.size)) r = i;
        else if (int'(free_seg[i].addr) + int'(free_seg[i].size) == int'(s.addr)) l = i;
      end
      if (l < 0 && r < 0) begin
        slot = first_free_slot();
        if (slot < 0) return csa_pkg::ST_FULL;
      end
      used_seg[u].vld = 1'b0;
      if (l >= 0) begin
        free_seg[l].size += s.size;
        if (r >= 0) begin
          free_seg[l].size += free_seg[r].size;
          free_seg[r].vld = 1'b0;
        end
      end else if (r >= 0) begin
        free_seg[r].addr = s.addr;
        free_seg[r].size += s.size;
      end else begin
        free_seg[slot] = s;
        free_seg[slot].vld = 1'b1;
      end
      return csa_pkg::ST_OK;
    endfunction

    function void note_word(csa_pkg::op_e op, logic [SW-1:0] req, logic [AW-1:0] addr);
      logic [AW-1:0] granted;
      csa_pkg::status_e st;
      granted = '0;
      if (op == csa_pkg::OP_RESERVE) st = reserve(int'(req), granted);
      else st = release_seg(addr);
      if (st != csa_pkg::ST_OK) granted = '0;
      exp_addr_q.push_back(granted);
      exp_status_q.push_back(st);
    endfunction

    function void check(logic [AW-1:0] granted, logic [2:0] status);
      logic [AW-1:0] ea;
      csa_pkg::status_e es;
      if (exp_status_q.size() == 0) begin
        $error("unexpected result word: granted_address %0d status %0d", granted, status);
        errors++;
        return;
      end
      ea = exp_addr_q.pop_front();
      es = exp_status_q.pop_front();
      if (granted !== ea) begin
        $error("granted_address: expected %0d, actual %0d", ea, granted);
        errors++;
      end
      if (status !== es) begin
        $error("status: expected %0d, actual %0d", es, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic op_i;
  logic [SW-1:0] request_size_i;
  logic [AW-1:0] address_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [AW-1:0] granted_address_o;
  logic [2:0] status_o;
  logic cfg_we_i;
  logic [SW-1:0] cfg_data_i;

  segment_scoreboard sb;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  coalescing_segment_allocator_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i(op_i),
    .request_size_i(request_size_i),
    .address_i(address_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .granted_address_o(granted_address_o),
    .status_o(status_o),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(granted_address_o, status_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(csa_pkg::op_e op, logic [SW-1:0] req, logic [AW-1:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    request_size_i <= req;
    address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(op, req, addr);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.exp_status_q.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_chunk_size(logic [SW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.note_cfg(value);
    @(posedge clk_i);
  endtask

  task automatic random_word();
    int unsigned pick;
    logic [SW-1:0] req;
    pick = $urandom_range(99);
    if (pick < 45) begin
      req = SW'($urandom_range(1, 64));
      if ($urandom_range(9) == 0) req = SW'($urandom_range(65, 256));
      send_word(csa_pkg::OP_RESERVE, req, AW'($urandom()));
    end else if (pick < 50) begin
      send_word(csa_pkg::OP_RESERVE, SW'(256), AW'($urandom()));
    end else if (pick < 55) begin
      send_word(csa_pkg::OP_RESERVE, SW'($urandom()), AW'($urandom()));
    end else if (pick < 92) begin
      send_word(csa_pkg::OP_RELEASE, SW'($urandom()), sb.pick_allocated());
    end else begin
      send_word(csa_pkg::OP_RELEASE, SW'($urandom()), AW'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 37;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = 1'b0;
    request_size_i = '0;
    address_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A chunk size of zero rejects every reserve.
    write_chunk_size('0);
    send_word(csa_pkg::OP_RESERVE, SW'(1), '0);
    send_word(csa_pkg::OP_RESERVE, '0, '1);
    send_word(csa_pkg::OP_RELEASE, '1, '0);
    send_word(csa_pkg::OP_RELEASE, '0, '1);
    wait_idle();

    // The largest register value acts as 65536.
    write_chunk_size('1);
    send_word(csa_pkg::OP_RESERVE, SW'(65537), '0);
    send_word(csa_pkg::OP_RESERVE, '1, '0);
    send_word(csa_pkg::OP_RESERVE, '0, '0);
    wait_idle();

    write_chunk_size(SW'(256));
    send_word(csa_pkg::OP_RESERVE, SW'(256), '0);
    send_word(csa_pkg::OP_RESERVE, SW'(257), '0);
    send_word(csa_pkg::OP_RESERVE, SW'(1), '0);
    send_word(csa_pkg::OP_RESERVE, SW'(1), '0);
    send_word(csa_pkg::OP_RESERVE, SW'(100), '0);
    send_word(csa_pkg::OP_RESERVE, SW'(100), '0);
    send_word(csa_pkg::OP_RELEASE, '0, AW'(257));
    send_word(csa_pkg::OP_RELEASE, '0, AW'(257));
    send_word(csa_pkg::OP_RELEASE, '0, AW'(258));
    send_word(csa_pkg::OP_RELEASE, '0, AW'(256));
    send_word(csa_pkg::OP_RELEASE, '0, AW'(358));
    send_word(csa_pkg::OP_RELEASE, '0, '0);
    send_word(csa_pkg::OP_RESERVE, SW'(255), '0);
    send_word(csa_pkg::OP_RELEASE, '0, '1);
    wait_idle();

    // Chunks are open now, so this write must be ignored.
    write_chunk_size(SW'(1));

    for (int i = 0; i < 1600; i++) begin
      idle_pct = (i >= 600 && i < 900) ? 0 : 37;
      if (i == 800) begin
        wait_idle();
        write_chunk_size('1);
      end
      random_word();
    end
    wait_idle();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
